@@ hw/rtl/tap_pkg.sv @@
// Shared types and constants of the three-axis attitude PID.
`default_nettype none

package tap_pkg;

    localparam int STICK_W     = 11;
    localparam int MEAS_W      = 18;
    localparam int GAIN_W      = 16;
    localparam int INTEG_W     = 32;
    localparam int SUM_W       = 40;
    localparam int DRIVE_W     = 24;
    localparam int LANE_STAGES = 11;

    localparam int STICK_CENTER = 1024;
    // 1920/672 reduces to 20/7 and 9600/672 to 100/7
    localparam int SP_GAIN_ANGLE = 20;
    localparam int SP_GAIN_RATE  = 100;

    // floor(n/7) = (n*RECIP7) >> 20 for n below 2^18
    localparam int              RECIP7_W  = 18;
    localparam logic [17:0]     RECIP7    = 18'd149797;
    localparam int              RECIP7_SH = 20;

    // floor(n/1000) = (n*RECIP_KA) >> 41 for n below 2^32
    localparam int              RECIP_KA_W  = 32;
    localparam logic [31:0]     RECIP_KA    = 32'd2199023256;
    localparam int              RECIP_KA_SH = 41;

    // floor(n/1000) = (n*RECIP_KB) >> 36 for n below 2^26
    localparam int              RECIP_KB_W  = 27;
    localparam logic [26:0]     RECIP_KB    = 27'd68719477;
    localparam int              RECIP_KB_SH = 36;

    localparam int KI_DIV = 1000;

    localparam logic [GAIN_W-1:0] KP_ROLL_RST  = 16'd1536;
    localparam logic [GAIN_W-1:0] KI_ROLL_RST  = 16'd0;
    localparam logic [GAIN_W-1:0] KD_ROLL_RST  = 16'd384;
    localparam logic [GAIN_W-1:0] KP_PITCH_RST = 16'd1536;
    localparam logic [GAIN_W-1:0] KI_PITCH_RST = 16'd0;
    localparam logic [GAIN_W-1:0] KD_PITCH_RST = 16'd384;
    localparam logic [GAIN_W-1:0] KP_YAW_RST   = 16'd512;
    localparam logic [GAIN_W-1:0] KD_YAW_RST   = 16'd1024;

    typedef enum logic [2:0] {
        CFG_KP_ROLL  = 3'd0,
        CFG_KI_ROLL  = 3'd1,
        CFG_KD_ROLL  = 3'd2,
        CFG_KP_PITCH = 3'd3,
        CFG_KI_PITCH = 3'd4,
        CFG_KD_PITCH = 3'd5,
        CFG_KP_YAW   = 3'd6,
        CFG_KD_YAW   = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic adv;   // all stages shift
        logic upd;   // integral takes the new sum
    } t_lane_ctl;

endpackage

`default_nettype wire

@@ hw/rtl/tap_lane.sv @@
// One axis lane: setpoint, error, saturating integral and PID sum.
`default_nettype none

module tap_lane
    import tap_pkg::*;
#(
    parameter int SP_GAIN = 20
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_lane_ctl                i_ctl,
    input  logic [STICK_W-1:0]       i_stick,
    input  logic signed [MEAS_W-1:0] i_meas,
    input  logic signed [MEAS_W-1:0] i_rate,
    input  logic [GAIN_W-1:0]        i_kp,
    input  logic [GAIN_W-1:0]        i_ki,
    input  logic [GAIN_W-1:0]        i_kd,
    output logic signed [SUM_W-1:0]  o_sum
);

    localparam int NW   = $clog2(STICK_CENTER * SP_GAIN + 1);
    localparam int SPW  = NW + 1;
    localparam int EW   = ((SPW > MEAS_W) ? SPW : MEAS_W) + 1;
    localparam int PEW  = GAIN_W + 1 + EW;
    localparam int DEW  = GAIN_W + 1 + MEAS_W;
    localparam int QAW  = 22;
    localparam int RAW  = 10;
    localparam int KQW  = GAIN_W + QAW;
    localparam int KRW  = GAIN_W + RAW;
    localparam int FRW  = GAIN_W;
    localparam int P7W  = NW + RECIP7_W;
    localparam int PAW  = INTEG_W + RECIP_KA_W;
    localparam int PBW  = KRW + RECIP_KB_W;

    // stage 0: captured transaction
    logic [STICK_W-1:0]       r_s0_stick;
    logic signed [MEAS_W-1:0] r_s0_meas;
    logic signed [MEAS_W-1:0] r_s0_rate;
    // stage 1: |stick - center| * gain
    logic [NW-1:0]            r_s1_n;
    logic                     r_s1_neg;
    logic signed [MEAS_W-1:0] r_s1_meas;
    logic signed [MEAS_W-1:0] r_s1_rate;
    // stage 2: quotient by 7
    logic [NW-1:0]            r_s2_q;
    logic                     r_s2_neg;
    logic signed [MEAS_W-1:0] r_s2_meas;
    logic signed [MEAS_W-1:0] r_s2_rate;
    // stage 3: error and integral
    logic signed [EW-1:0]      r_s3_e;
    logic signed [INTEG_W-1:0] r_s3_acc;
    logic signed [MEAS_W-1:0]  r_s3_rate;
    logic signed [INTEG_W-1:0] r_int;
    // stage 4 onward
    logic signed [PEW-1:0]     r_pe   [4:9];
    logic signed [DEW-1:0]     r_de   [4:9];
    logic                      r_aneg [4:9];
    logic [INTEG_W-1:0]        r_amag [4:5];
    logic [QAW-1:0]            r_s5_qa;
    logic [RAW-1:0]            r_s6_ra;
    logic [KQW-1:0]            r_kq   [6:8];
    logic [KRW-1:0]            r_s7_kr;
    logic [FRW-1:0]            r_s8_fr;
    logic [KQW-1:0]            r_s9_it;
    logic signed [SUM_W-1:0]   r_s10_sum;

    logic signed [STICK_W:0]   w_d;
    logic [STICK_W-1:0]        w_mag;
    logic [NW-1:0]             n_s1_n;
    logic [P7W-1:0]            w_p7;
    logic signed [SPW-1:0]     w_sp;
    logic signed [EW-1:0]      n_s3_e;
    logic signed [INTEG_W:0]   w_add;
    logic signed [INTEG_W-1:0] n_acc;
    logic [INTEG_W-1:0]        n_amag;
    logic [PAW-1:0]            w_pa;
    logic [RAW-1:0]            n_ra;
    logic [KQW-1:0]            n_kq;
    logic [PBW-1:0]            w_pb;
    logic signed [SUM_W-1:0]   w_its;
    logic signed [SUM_W-1:0]   n_sum;

    always_comb begin
        w_d    = $signed({1'b0, r_s0_stick}) - $signed((STICK_W + 1)'(STICK_CENTER));
        w_mag  = w_d[STICK_W] ? STICK_W'(-w_d) : w_d[STICK_W-1:0];
        n_s1_n = NW'(w_mag * SP_GAIN);
        w_p7   = r_s1_n * RECIP7;
    end

    // setpoint error and saturating integral
    always_comb begin
        w_sp   = r_s2_neg ? -$signed({1'b0, r_s2_q}) : $signed({1'b0, r_s2_q});
        n_s3_e = EW'(w_sp) - EW'(r_s2_meas);
        w_add  = (INTEG_W + 1)'(r_int) + (INTEG_W + 1)'(n_s3_e);
        if (w_add[INTEG_W] != w_add[INTEG_W-1]) begin
            n_acc = w_add[INTEG_W] ? {1'b1, {(INTEG_W - 1){1'b0}}}
                                   : {1'b0, {(INTEG_W - 1){1'b1}}};
        end else begin
            n_acc = w_add[INTEG_W-1:0];
        end
    end

    // ki*|acc|/1000 = ki*qa + ki*ra/1000 with |acc| = 1000*qa + ra
    always_comb begin
        n_amag = r_s3_acc[INTEG_W-1] ? INTEG_W'(-r_s3_acc) : INTEG_W'(r_s3_acc);
        w_pa   = r_amag[4] * RECIP_KA;
        n_ra   = RAW'(r_amag[5] - INTEG_W'(r_s5_qa * KI_DIV));
        n_kq   = i_ki * r_s5_qa;
        w_pb   = r_s7_kr * RECIP_KB;
        w_its  = r_aneg[9] ? -$signed({2'b00, r_s9_it}) : $signed({2'b00, r_s9_it});
        n_sum  = SUM_W'(r_pe[9]) - SUM_W'(r_de[9]) + w_its;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int <= '0;
        end else if (i_ctl.upd) begin
            r_int <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_s0_stick <= i_stick;
            r_s0_meas  <= i_meas;
            r_s0_rate  <= i_rate;

            r_s1_n     <= n_s1_n;
            r_s1_neg   <= w_d[STICK_W];
            r_s1_meas  <= r_s0_meas;
            r_s1_rate  <= r_s0_rate;

            r_s2_q     <= NW'(w_p7 >> RECIP7_SH);
            r_s2_neg   <= r_s1_neg;
            r_s2_meas  <= r_s1_meas;
            r_s2_rate  <= r_s1_rate;

            r_s3_e     <= n_s3_e;
            r_s3_acc   <= n_acc;
            r_s3_rate  <= r_s2_rate;

            r_pe[4]    <= $signed({1'b0, i_kp}) * r_s3_e;
            r_de[4]    <= $signed({1'b0, i_kd}) * r_s3_rate;
            r_aneg[4]  <= r_s3_acc[INTEG_W-1];
            r_amag[4]  <= n_amag;

            r_s5_qa    <= QAW'(w_pa >> RECIP_KA_SH);
            r_amag[5]  <= r_amag[4];

            r_s6_ra    <= n_ra;
            r_kq[6]    <= n_kq;

            r_s7_kr    <= i_ki * r_s6_ra;
            r_kq[7]    <= r_kq[6];

            r_s8_fr    <= FRW'(w_pb >> RECIP_KB_SH);
            r_kq[8]    <= r_kq[7];

            r_s9_it    <= r_kq[8] + KQW'(r_s8_fr);

            r_s10_sum  <= n_sum;

            for (int k = 5; k <= 9; k++) begin
                r_pe[k]   <= r_pe[k-1];
                r_de[k]   <= r_de[k-1];
                r_aneg[k] <= r_aneg[k-1];
            end
        end
    end

    assign o_sum = r_s10_sum;

endmodule

`default_nettype wire

@@ hw/rtl/tap_merge.sv @@
// Merge stage: scale and saturate the three lane sums into the output register.
`default_nettype none

module tap_merge
    import tap_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_adv,
    input  logic                      i_vld,
    input  logic signed [SUM_W-1:0]   i_sum_roll,
    input  logic signed [SUM_W-1:0]   i_sum_pitch,
    input  logic signed [SUM_W-1:0]   i_sum_yaw,
    input  logic [STICK_W-1:0]        i_throttle,
    output logic                      o_valid,
    output logic signed [DRIVE_W-1:0] o_roll,
    output logic signed [DRIVE_W-1:0] o_pitch,
    output logic signed [DRIVE_W-1:0] o_yaw,
    output logic [STICK_W-1:0]        o_throttle
);

    localparam int QW = SUM_W - 8;

    function automatic logic signed [DRIVE_W-1:0] drive_sat(input logic signed [SUM_W-1:0] s);
        logic signed [QW-1:0] q;
        logic signed [DRIVE_W-1:0] d;
        // floor divide by 256
        q = QW'(s >>> 8);
        if (q[QW-1:DRIVE_W-1] == '0 || q[QW-1:DRIVE_W-1] == '1) begin
            d = q[DRIVE_W-1:0];
        end else if (q[QW-1]) begin
            d = {1'b1, {(DRIVE_W - 1){1'b0}}};
        end else begin
            d = {1'b0, {(DRIVE_W - 1){1'b1}}};
        end
        return d;
    endfunction

    logic                      r_valid;
    logic signed [DRIVE_W-1:0] r_roll;
    logic signed [DRIVE_W-1:0] r_pitch;
    logic signed [DRIVE_W-1:0] r_yaw;
    logic [STICK_W-1:0]        r_throttle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_roll     <= drive_sat(i_sum_roll);
            r_pitch    <= drive_sat(i_sum_pitch);
            r_yaw      <= drive_sat(i_sum_yaw);
            r_throttle <= i_throttle;
        end
    end

    assign o_valid    = r_valid;
    assign o_roll     = r_roll;
    assign o_pitch    = r_pitch;
    assign o_yaw      = r_yaw;
    assign o_throttle = r_throttle;

endmodule

`default_nettype wire

@@ hw/rtl/three_axis_attitude_pid.sv @@
// Top level: gain registers, three axis lanes, valid pipeline and output merge.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------------------
//  in      | to block  | i_in_valid / o_in_stall   | sticks, angles, rates
//  out     | from block| o_out_valid / i_out_stall | roll/pitch/yaw drive, throttle
//  cfg     | to block  | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One transaction per cycle while the output is not stalled. The accepting edge loads lane
// stage 0; a result then passes lane stages 1 to 10, most of them the divide-by-1000
// reciprocal chain of the integral term, and then the output register.
// Reset clears the valid pipeline, the output valid, the three integrals and
// loads the default gains.
// A stalled result freezes the whole pipeline and raises o_in_stall.
`default_nettype none

module three_axis_attitude_pid
    import tap_pkg::*;
#(
    parameter logic [15:0] KI_YAW = 16'd0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [STICK_W-1:0]        i_stick_roll,
    input  logic [STICK_W-1:0]        i_stick_pitch,
    input  logic [STICK_W-1:0]        i_stick_throttle,
    input  logic [STICK_W-1:0]        i_stick_yaw,
    input  logic signed [MEAS_W-1:0]  i_roll_angle,
    input  logic signed [MEAS_W-1:0]  i_pitch_angle,
    input  logic signed [MEAS_W-1:0]  i_roll_rate,
    input  logic signed [MEAS_W-1:0]  i_pitch_rate,
    input  logic signed [MEAS_W-1:0]  i_yaw_rate,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [DRIVE_W-1:0] o_roll_drive,
    output logic signed [DRIVE_W-1:0] o_pitch_drive,
    output logic signed [DRIVE_W-1:0] o_yaw_drive,
    output logic [STICK_W-1:0]        o_throttle_out,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [2:0]                i_cfg_index,
    input  logic [GAIN_W-1:0]         i_cfg_data
);

    localparam int LAST = LANE_STAGES - 1;

    logic [GAIN_W-1:0] r_kp_roll, r_ki_roll, r_kd_roll;
    logic [GAIN_W-1:0] r_kp_pitch, r_ki_pitch, r_kd_pitch;
    logic [GAIN_W-1:0] r_kp_yaw, r_kd_yaw;

    logic [LANE_STAGES-1:0] r_vld;
    logic [STICK_W-1:0]     r_thr [0:LAST];

    logic                    w_adv;
    t_lane_ctl               w_ctl;
    logic signed [SUM_W-1:0] w_sum_roll, w_sum_pitch, w_sum_yaw;

    assign o_in_stall  = o_out_valid & i_out_stall;
    assign w_adv       = ~o_in_stall;
    assign w_ctl.adv   = w_adv;
    assign w_ctl.upd   = w_adv & r_vld[2];
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp_roll  <= KP_ROLL_RST;
            r_ki_roll  <= KI_ROLL_RST;
            r_kd_roll  <= KD_ROLL_RST;
            r_kp_pitch <= KP_PITCH_RST;
            r_ki_pitch <= KI_PITCH_RST;
            r_kd_pitch <= KD_PITCH_RST;
            r_kp_yaw   <= KP_YAW_RST;
            r_kd_yaw   <= KD_YAW_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_KP_ROLL:  r_kp_roll  <= i_cfg_data;
                CFG_KI_ROLL:  r_ki_roll  <= i_cfg_data;
                CFG_KD_ROLL:  r_kd_roll  <= i_cfg_data;
                CFG_KP_PITCH: r_kp_pitch <= i_cfg_data;
                CFG_KI_PITCH: r_ki_pitch <= i_cfg_data;
                CFG_KD_PITCH: r_kd_pitch <= i_cfg_data;
                CFG_KP_YAW:   r_kp_yaw   <= i_cfg_data;
                CFG_KD_YAW:   r_kd_yaw   <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[LANE_STAGES-2:0], i_in_valid};
        end
    end

    // throttle rides alongside the lanes
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_thr[0] <= i_stick_throttle;
            for (int k = 1; k <= LAST; k++) begin
                r_thr[k] <= r_thr[k-1];
            end
        end
    end

    tap_lane #(
        .SP_GAIN (SP_GAIN_ANGLE)
    ) u_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_stick (i_stick_roll),
        .i_meas  (i_roll_angle),
        .i_rate  (i_roll_rate),
        .i_kp    (r_kp_roll),
        .i_ki    (r_ki_roll),
        .i_kd    (r_kd_roll),
        .o_sum   (w_sum_roll)
    );

    tap_lane #(
        .SP_GAIN (SP_GAIN_ANGLE)
    ) u_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_stick (i_stick_pitch),
        .i_meas  (i_pitch_angle),
        .i_rate  (i_pitch_rate),
        .i_kp    (r_kp_pitch),
        .i_ki    (r_ki_pitch),
        .i_kd    (r_kd_pitch),
        .o_sum   (w_sum_pitch)
    );

    // yaw regulates rate: the rate is both the measurement and the damping input
    tap_lane #(
        .SP_GAIN (SP_GAIN_RATE)
    ) u_yaw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_stick (i_stick_yaw),
        .i_meas  (i_yaw_rate),
        .i_rate  (i_yaw_rate),
        .i_kp    (r_kp_yaw),
        .i_ki    (KI_YAW),
        .i_kd    (r_kd_yaw),
        .o_sum   (w_sum_yaw)
    );

    tap_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (w_adv),
        .i_vld       (r_vld[LAST]),
        .i_sum_roll  (w_sum_roll),
        .i_sum_pitch (w_sum_pitch),
        .i_sum_yaw   (w_sum_yaw),
        .i_throttle  (r_thr[LAST]),
        .o_valid     (o_out_valid),
        .o_roll      (o_roll_drive),
        .o_pitch     (o_pitch_drive),
        .o_yaw       (o_yaw_drive),
        .o_throttle  (o_throttle_out)
    );

    a_reset_clears : assert property (@(posedge i_clk)
        !i_rst_n |=> (r_vld == '0) && !o_out_valid)
        else $error("pipeline not empty after reset");

    a_accept_enters : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_vld[0])
        else $error("accepted transaction missing from first stage");

    a_last_to_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_vld[LAST]) |=> o_out_valid)
        else $error("finished transaction not presented");

    a_bubble_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && !r_vld[LAST]) |=> !o_out_valid)
        else $error("result invented from a bubble");

    a_freeze : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_vld))
        else $error("pipeline moved while stalled");

endmodule

`default_nettype wire
